FILE: design/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the circular queue with search: opcodes,
// status codes, field widths and the default queue depth.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int FQS_DEPTH = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ     = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_DISPLAY = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

endpackage

FILE: design/fqs_ram.sv
// ----------------------------------------------------------------------------
// fqs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/fifo_queue_with_search_core.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search_core
// Circular FIFO of signed 32-bit values with enqueue, dequeue, search and display.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Enqueue, and any
// dequeue, search or display on an empty queue, answers with one result in
// the cycle after the item is taken and busy stays low, so a new item can be
// taken every cycle. Dequeue reads the head when it is taken and answers from
// state S_DEQ. Display and a search that misses walk all stored entries;
// a search that hits at position P from the head stops there. The ring
// store has one read port and the walk reads one entry per cycle. Display
// gives one result per entry on consecutive cycles; result_valid marks each
// and last marks the final one. Results cannot be held off: each shows for
// exactly one cycle.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_core
    import fqs_pkg::*;
#(
    parameter int DEPTH = FQS_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic signed [DATA_W-1:0]   data_value,
    output logic                       result_valid,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   out_value,
    output logic [POS_W-1:0]           position,
    output logic                       last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_WALK
    } state_t;

    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic signed [DATA_W-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          rptr_reg, rptr_next;
    logic [CNT_W-1:0]          issued_reg, issued_next;
    logic [IDX_W-1:0]          didx_reg, didx_next;

    logic                      valid_reg, valid_next;
    status_t                   status_reg, status_next;
    logic signed [DATA_W-1:0]  value_reg, value_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      last_reg, last_next;

    logic                      accept;
    op_t                       op_in;
    logic                      is_full;
    logic                      is_empty;
    logic                      wr_en;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [DATA_W-1:0]  rd_data;
    logic                      walk_last;
    logic [IDX_W+POS_W-1:0]    didx_ext;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        begin
            r = (p == LAST_IDX) ? '0 : p + 1'b1;
            return r;
        end
    endfunction

    assign accept   = start && !busy;
    assign op_in    = op_t'(opcode);
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign busy     = (state_reg != S_IDLE);

    assign wr_en    = accept && (op_in == OP_ENQ) && !is_full;
    assign didx_ext = {{POS_W{1'b0}}, didx_reg};
    assign walk_last = ((CNT_W'(didx_reg) + 1'b1) == count_reg);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_en   = accept && (op_in != OP_ENQ) && !is_empty;
                rd_addr = head_reg;
            end
            S_WALK:
            begin
                rd_en   = (issued_reg < count_reg);
                rd_addr = rptr_reg;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = head_reg;
            end
        endcase
    end

    fqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (data_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        rptr_next   = rptr_reg;
        issued_next = issued_reg;
        didx_next   = didx_reg;
        valid_next  = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_in;
                    key_next = data_value;
                    if (op_in == OP_ENQ)
                    begin
                        valid_next = 1'b1;
                        value_next = '0;
                        pos_next   = '0;
                        last_next  = 1'b1;
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            tail_next   = wrap_inc(tail_reg);
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    else if (is_empty)
                    begin
                        valid_next  = 1'b1;
                        status_next = ST_EMPTY;
                        value_next  = '0;
                        pos_next    = '0;
                        last_next   = 1'b1;
                    end
                    else if (op_in == OP_DEQ)
                    begin
                        state_next = S_DEQ;
                    end
                    else
                    begin
                        // head read is in flight; walk the rest from head + 1
                        state_next  = S_WALK;
                        rptr_next   = wrap_inc(head_reg);
                        issued_next = CNT_W'(1);
                        didx_next   = '0;
                    end
                end
            end

            S_DEQ:
            begin
                valid_next  = 1'b1;
                status_next = ST_OK;
                value_next  = rd_data;
                pos_next    = '0;
                last_next   = 1'b1;
                head_next   = wrap_inc(head_reg);
                count_next  = count_reg - 1'b1;
                state_next  = S_IDLE;
            end

            S_WALK:
            begin
                if (rd_en)
                begin
                    rptr_next   = wrap_inc(rptr_reg);
                    issued_next = issued_reg + 1'b1;
                end
                didx_next = didx_reg + 1'b1;
                if (op_reg == OP_DISPLAY)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    value_next  = rd_data;
                    pos_next    = didx_ext[POS_W-1:0];
                    last_next   = walk_last;
                    if (walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (rd_data == key_reg)
                begin
                    // first hit from the head ends the search
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    value_next  = '0;
                    pos_next    = didx_ext[POS_W-1:0];
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (walk_last)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_MISS;
                    value_next  = '0;
                    pos_next    = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            rptr_reg   <= '0;
            issued_reg <= '0;
            didx_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            rptr_reg   <= rptr_next;
            issued_reg <= issued_next;
            didx_reg   <= didx_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign out_value    = value_reg;
    assign position     = pos_reg;
    assign last         = last_reg;

    // count stays within the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds depth");

    // tail always sits count entries past head
    assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg) == (CNT_W + 1)'(tail_reg))
        || ((CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg)
            == (CNT_W + 1)'(tail_reg) + (CNT_W + 1)'(DEPTH)))
        else $error("tail pointer out of step with head and count");

    // a full report leaves the queue full
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (status_reg == ST_FULL)) |-> is_full)
        else $error("full status reported on a queue that is not full");

    // an enqueue never holds the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_in == OP_ENQ)) |=> !busy)
        else $error("enqueue left the block busy");

    // the store is never written while a walk or dequeue is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr_en)
        else $error("store written while busy");

endmodule

FILE: bench/tb_fifo_queue_with_search_core.sv
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_search_core
// Self-checking bench for the circular queue with search and display. A
// scoreboard keeps its own copy of the ring and predicts every result of
// each accepted item. Directed items cover the empty and full cases, the
// value extremes and first-match search. Random fill and drain runs with
// random gaps follow.
// ----------------------------------------------------------------------------
import fqs_pkg::*;

class queue_scoreboard;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        logic                     last;
    } answer_t;

    logic signed [DATA_W-1:0] ring [FQS_DEPTH];
    logic [POS_W-1:0]         head;
    logic [POS_W:0]           count;
    answer_t                  answers_q[$];

    int fail_count;
    int checked_count;
    int full_count;
    int empty_count;
    int op_count [4];

    function new();
        foreach (ring[i])
            ring[i] = '0;
        head          = '0;
        count         = '0;
        fail_count    = 0;
        checked_count = 0;
        full_count    = 0;
        empty_count   = 0;
        foreach (op_count[i])
            op_count[i] = 0;
    endfunction

    function int pending();
        return answers_q.size();
    endfunction

    function logic signed [DATA_W-1:0] peek(int i);
        return ring[(int'(head) + i) % FQS_DEPTH];
    endfunction

    function void push_answer(status_t st, logic signed [DATA_W-1:0] value,
                              logic [POS_W-1:0] pos, logic last);
        answer_t a;
        a.status = st;
        a.value  = value;
        a.pos    = pos;
        a.last   = last;
        answers_q.push_back(a);
    endfunction

    // Work out every result that one accepted item causes.
    function void note_item(op_t op, logic signed [DATA_W-1:0] val);
        int hit;
        op_count[op]++;
        if (op == OP_ENQ) begin
            if (count >= FQS_DEPTH) begin
                full_count++;
                push_answer(ST_FULL, '0, '0, 1'b1);
            end
            else begin
                ring[(int'(head) + int'(count)) % FQS_DEPTH] = val;
                count++;
                push_answer(ST_OK, '0, '0, 1'b1);
            end
        end
        else if (count == 0) begin
            empty_count++;
            push_answer(ST_EMPTY, '0, '0, 1'b1);
        end
        else if (op == OP_DEQ) begin
            push_answer(ST_OK, ring[head], '0, 1'b1);
            head = POS_W'((int'(head) + 1) % FQS_DEPTH);
            count--;
        end
        else if (op == OP_SEARCH) begin
            hit = -1;
            for (int i = 0; i < int'(count); i++)
                if (hit < 0 && peek(i) == val)
                    hit = i;
            if (hit < 0)
                push_answer(ST_MISS, '0, '0, 1'b1);
            else
                push_answer(ST_OK, '0, POS_W'(hit), 1'b1);
        end
        else begin
            for (int i = 0; i < int'(count); i++)
                push_answer(ST_OK, peek(i), POS_W'(i), i + 1 == int'(count));
        end
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic signed [DATA_W-1:0] value,
                      logic [POS_W-1:0] pos, logic last);
        answer_t a;
        if (answers_q.size() == 0) begin
            report($sformatf("unexpected result status=%0d value=%0d pos=%0d last=%0b",
                             status, value, pos, last));
        end
        else begin
            a = answers_q.pop_front();
            checked_count++;
            if (status !== a.status)
                report($sformatf("status got %0d want %0d", status, a.status));
            if (value !== a.value)
                report($sformatf("out_value got %0d want %0d", value, a.value));
            if (pos !== a.pos)
                report($sformatf("position got %0d want %0d", pos, a.pos));
            if (last !== a.last)
                report($sformatf("last got %0b want %0b", last, a.last));
        end
    endtask

endclass

module tb_fifo_queue_with_search_core;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 220;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] data_value;
    logic                     result_valid;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         position;
    logic                     last;

    queue_scoreboard sb;
    int              cycle_count;

    fifo_queue_with_search_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .data_value   (data_value),
        .result_valid (result_valid),
        .status       (status),
        .out_value    (out_value),
        .position     (position),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check results before noting a new item: a result never belongs to the
    // item taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid)
                sb.check_result(status, out_value, position, last);
            if (start && !busy)
                sb.note_item(op_t'(opcode), data_value);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Hold the item until it is taken.
    task automatic issue(op_t op, logic signed [DATA_W-1:0] val);
        opcode     <= op;
        data_value <= val;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            start      <= 1'b0;
            data_value <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return $urandom_range(0, 15) - 8;
            8:             return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
    endfunction

    // Mostly search for something that is stored, so hits land everywhere.
    function automatic logic signed [DATA_W-1:0] search_value();
        if (sb.count != 0 && $urandom_range(0, 9) < 6)
            return sb.peek($urandom_range(0, int'(sb.count) - 1));
        return pick_value();
    endfunction

    function automatic op_t pick_op(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 60)      return OP_ENQ;
            else if (r < 75) return OP_DEQ;
            else if (r < 90) return OP_SEARCH;
        end
        else begin
            if (r < 15)      return OP_ENQ;
            else if (r < 70) return OP_DEQ;
            else if (r < 90) return OP_SEARCH;
        end
        return OP_DISPLAY;
    endfunction

    initial
    begin
        bit  filling;
        bit  quiet;
        op_t op;

        sb         = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_ENQ;
        data_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue answers
        issue(OP_DISPLAY, 32'h0000_0000);
        issue(OP_DEQ, 32'hFFFF_FFFF);
        issue(OP_SEARCH, 32'h0000_0000);
        pause(gap_length());

        // Value extremes, search hit and miss, dequeue of the oldest
        issue(OP_ENQ, 32'h8000_0000);
        issue(OP_ENQ, 32'h7FFF_FFFF);
        pause(gap_length());
        issue(OP_ENQ, 32'h0000_0000);
        issue(OP_ENQ, 32'hFFFF_FFFF);
        issue(OP_SEARCH, 32'hFFFF_FFFF);
        issue(OP_SEARCH, 32'h0000_3039);
        issue(OP_DEQ, 32'h0000_0000);
        pause(gap_length());

        // Fill to the brim with a duplicate, then overflow, display and search
        // for the tail and for the first of two matches.
        for (int k = 0; k < 12; k++) begin
            issue(OP_ENQ, (k == 5) ? 32'hFFFF_FFFF : pick_value());
            pause(gap_length());
        end
        issue(OP_ENQ, 32'h5A5A_A5A5);
        issue(OP_ENQ, 32'h0000_0001);
        issue(OP_DISPLAY, 32'h0000_0000);
        issue(OP_SEARCH, 32'h5A5A_A5A5);
        issue(OP_SEARCH, 32'hFFFF_FFFF);
        drain();

        // Random fill and drain runs; some bursts keep start high throughout.
        filling = 1'b0;
        quiet   = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 20 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain();
            if (sb.count == 0)
                filling = 1'b1;
            else if (sb.count == FQS_DEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            op = pick_op(filling);
            issue(op, (op == OP_SEARCH) ? search_value() : pick_value());
            if (!quiet)
                pause(gap_length());
        end

        drain();
        repeat (FQS_DEPTH + 4) @(posedge clk);

        $display("Ran %0d items: %0d enqueue, %0d dequeue, %0d search, %0d display",
                 sb.op_count[OP_ENQ] + sb.op_count[OP_DEQ] + sb.op_count[OP_SEARCH]
                 + sb.op_count[OP_DISPLAY], sb.op_count[OP_ENQ], sb.op_count[OP_DEQ],
                 sb.op_count[OP_SEARCH], sb.op_count[OP_DISPLAY]);
        $display("Checked %0d results, %0d full drops, %0d empty-queue answers",
                 sb.checked_count, sb.full_count, sb.empty_count);
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/fqs_pkg.sv
design/fqs_ram.sv
design/fifo_queue_with_search_core.sv
bench/tb_fifo_queue_with_search_core.sv
